// ===== rtl/ipvs_pkg.sv =====
// ----------------------------------------------------------------------------
// ipvs_pkg
// Shared types, codes, limits and step tables of the panel value stepper.
// ----------------------------------------------------------------------------
package ipvs_pkg;

  typedef enum logic [1:0] {
    REQ_KEY  = 2'd0,
    REQ_ENC  = 2'd1,
    REQ_TICK = 2'd2
  } req_e;

  typedef enum logic [3:0] {
    KEY_RF     = 4'd0,
    KEY_AMPL   = 4'd1,
    KEY_FM     = 4'd2,
    KEY_PM     = 4'd3,
    KEY_AM     = 4'd4,
    KEY_X10    = 4'd5,
    KEY_DIV10  = 4'd6,
    KEY_VALID  = 4'd7,
    KEY_RFOFF  = 4'd8,
    KEY_CW     = 4'd9,
    KEY_400HZ  = 4'd10,
    KEY_1KHZ   = 4'd11,
    KEY_EXT    = 4'd12
  } key_e;

  typedef enum logic [2:0] {
    TGT_FREQ = 3'd0,
    TGT_AMPL = 3'd1,
    TGT_FM   = 3'd2,
    TGT_PM   = 3'd3,
    TGT_AM   = 3'd4
  } tgt_e;

  typedef enum logic [1:0] {
    MOD_FM = 2'd0,
    MOD_PM = 2'd1,
    MOD_AM = 2'd2
  } mod_e;

  typedef enum logic [1:0] {
    EVT_NONE    = 2'd0,
    EVT_APPLIED = 2'd1,
    EVT_LOCKED  = 2'd2,
    EVT_LIMIT   = 2'd3
  } evt_e;

  typedef enum logic [1:0] {
    FLD_FREQ = 2'd0,
    FLD_MOD  = 2'd1,
    FLD_AMPL = 2'd2
  } fld_e;

  typedef enum logic [0:0] {
    CFG_BLINK_MS    = 1'b0,
    CFG_BLINK_TOTAL = 1'b1
  } cfg_e;

  // Limits of the adjustable parameters.
  localparam logic [29:0]        FREQ_MIN      = 30'd100000;
  localparam logic [29:0]        FREQ_MAX      = 30'd560000000;
  localparam logic signed [12:0] AMPL_OFFSET   = 13'sd1299;
  localparam logic [29:0]        AMPL_SPAN     = 30'd1429;
  localparam logic [17:0]        FM_MAX        = 18'd200000;
  localparam logic [10:0]        PM_MAX        = 11'd1999;
  localparam logic [9:0]         AM_MAX        = 10'd999;
  localparam logic [17:0]        FM_COARSE     = 18'd20000;
  localparam logic [26:0]        FM_MIN_STEP   = 27'd100;
  localparam logic signed [11:0] AMPL_RST      = -12'sd1299;
  localparam logic [15:0]        BLINK_MS_RST  = 16'd150;
  localparam logic [3:0]         BLINK_TOT_RST = 4'd6;
  localparam logic [8:0]         MOD_WIDE_MASK = 9'h007;

  typedef logic [2:0]        idx_t;
  typedef idx_t [4:0]        idx_vec_t;
  typedef logic [26:0]       step_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  key_code;
    logic        encoder_up;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    step_t      step;
    logic [1:0] field;
    logic [8:0] mask;
  } step_info_t;

  typedef struct packed {
    logic [1:0]        event_status;
    logic [29:0]       carrier_hz;
    logic signed [11:0] level_ddbm;
    logic [17:0]       mod_value;
    logic [2:0]        target;
    logic [2:0]        enc_target;
    logic [1:0]        mod_mode;
    logic [1:0]        mod_source;
    logic [1:0]        flags;
    step_t             current_step;
    logic [1:0]        blank_field;
    logic [8:0]        blank_mask;
  } result_t;

  // Highest step index of each target.
  function automatic idx_t max_index(input tgt_e t);
    case (t)
      TGT_AMPL: max_index = 3'd2;
      TGT_FM:   max_index = 3'd4;
      TGT_PM:   max_index = 3'd3;
      TGT_AM:   max_index = 3'd2;
      default:  max_index = 3'd7;
    endcase
  endfunction

  // Power-of-ten step of a target at a given index.
  function automatic step_t step_value(input tgt_e t, input idx_t i);
    step_value = 27'd1;
    case (t)
      TGT_AMPL, TGT_AM: begin
        case (i)
          3'd1:    step_value = 27'd10;
          3'd2:    step_value = 27'd100;
          default: step_value = 27'd1;
        endcase
      end
      TGT_FM: begin
        case (i)
          3'd1:    step_value = 27'd100;
          3'd2:    step_value = 27'd1000;
          3'd3:    step_value = 27'd10000;
          3'd4:    step_value = 27'd100000;
          default: step_value = 27'd10;
        endcase
      end
      TGT_PM: begin
        case (i)
          3'd1:    step_value = 27'd10;
          3'd2:    step_value = 27'd100;
          3'd3:    step_value = 27'd1000;
          default: step_value = 27'd1;
        endcase
      end
      default: begin
        case (i)
          3'd1:    step_value = 27'd100;
          3'd2:    step_value = 27'd1000;
          3'd3:    step_value = 27'd10000;
          3'd4:    step_value = 27'd100000;
          3'd5:    step_value = 27'd1000000;
          3'd6:    step_value = 27'd10000000;
          3'd7:    step_value = 27'd100000000;
          default: step_value = 27'd10;
        endcase
      end
    endcase
  endfunction

endpackage

// ===== rtl/ipvs_step.sv =====
// ----------------------------------------------------------------------------
// ipvs_step
// Effective wheel step, display field and digit blank mask of a wheel target.
// ----------------------------------------------------------------------------
module ipvs_step import ipvs_pkg::*; (
  input  tgt_e       target_i,
  input  idx_vec_t   idx_i,
  input  logic [17:0] fm_dev_i,
  input  logic       blank_on_i,
  output step_info_t info_o
);

  tgt_e       tgt;
  idx_t       idx_raw;
  idx_t       idx_max;
  idx_t       idx;
  step_t      step_raw;
  logic       coarse;
  logic [3:0] pos;
  fld_e       fld;

  always_comb begin
    tgt      = (target_i > TGT_AM) ? TGT_FREQ : target_i;
    idx_raw  = idx_i[tgt];
    idx_max  = max_index(tgt);
    idx      = (idx_raw > idx_max) ? idx_max : idx_raw;
    step_raw = step_value(tgt, idx);
    coarse   = (fm_dev_i >= FM_COARSE);

    info_o.step = step_raw;
    if (tgt == TGT_FM && coarse && step_raw < FM_MIN_STEP) begin
      info_o.step = FM_MIN_STEP;
    end

    case (tgt)
      TGT_AMPL:               fld = FLD_AMPL;
      TGT_FM, TGT_PM, TGT_AM: fld = FLD_MOD;
      default:                fld = FLD_FREQ;
    endcase
    info_o.field = fld;

    // Digit position of the step on the display. At or above the coarse FM
    // limit the resolution is 100 Hz, so the FM position drops by one.
    case (tgt)
      TGT_FREQ: pos = {1'b0, idx} + 4'd1;
      TGT_FM: begin
        if (coarse) begin
          pos = (idx == 3'd0) ? 4'd0 : {1'b0, idx - 3'd1};
        end else begin
          pos = {1'b0, idx};
        end
      end
      default:  pos = {1'b0, idx};
    endcase

    if (!blank_on_i) begin
      info_o.mask = '0;
    end else if (pos >= 4'd3 && fld == FLD_MOD) begin
      info_o.mask = MOD_WIDE_MASK;
    end else begin
      info_o.mask = 9'd1 << pos;
    end
  end

endmodule

// ===== rtl/ipvs_core.sv =====
// ----------------------------------------------------------------------------
// ipvs_core
// Panel state, configuration registers and the combinational event update.
// ----------------------------------------------------------------------------
module ipvs_core import ipvs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        advance_i,
  input  item_t       item_i,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  output result_t     res_o
);

  logic [29:0]        freq_q, freq_d;
  logic signed [11:0] ampl_q, ampl_d;
  logic [17:0]        fm_q, fm_d;
  logic [10:0]        pm_q, pm_d;
  logic [9:0]         am_q, am_d;
  tgt_e               sel_q, sel_d;
  tgt_e               enc_q, enc_d;
  mod_e               mode_q, mode_d;
  logic [1:0]         src_q, src_d;
  logic               rf_off_q, rf_off_d;
  logic               inhibit_q, inhibit_d;
  idx_vec_t           idx_q, idx_d;
  logic               act_q, act_d;
  logic               blank_q, blank_d;
  logic [3:0]         left_q, left_d;
  logic [31:0]        last_q, last_d;
  logic [15:0]        phase_ms_q;
  logic [3:0]         phase_tot_q;

  step_info_t  pre_info;
  step_info_t  post_info;
  logic [29:0] sat_v, sat_lo, sat_hi, sat_s, sat_n;
  logic [12:0] ampl_ofs;
  logic [12:0] ampl_back;
  logic        changed;
  evt_e        status;
  logic [31:0] elapsed;
  logic [3:0]  left_dec;
  idx_t        idx_cur;
  logic [17:0] modv;

  ipvs_step u_pre (
    .target_i  (enc_q),
    .idx_i     (idx_q),
    .fm_dev_i  (fm_q),
    .blank_on_i(1'b0),
    .info_o    (pre_info)
  );

  // Shared saturating adder for the wheel target. The level is moved to an
  // unsigned range by its offset so that one unit serves all targets.
  always_comb begin
    ampl_ofs = 13'({ampl_q[11], ampl_q} + AMPL_OFFSET);
    case (enc_q)
      TGT_AMPL: begin
        sat_v = {17'd0, ampl_ofs}; sat_lo = '0; sat_hi = AMPL_SPAN;
      end
      TGT_FM: begin
        sat_v = {12'd0, fm_q}; sat_lo = '0; sat_hi = {12'd0, FM_MAX};
      end
      TGT_PM: begin
        sat_v = {19'd0, pm_q}; sat_lo = '0; sat_hi = {19'd0, PM_MAX};
      end
      TGT_AM: begin
        sat_v = {20'd0, am_q}; sat_lo = '0; sat_hi = {20'd0, AM_MAX};
      end
      default: begin
        sat_v = freq_q; sat_lo = FREQ_MIN; sat_hi = FREQ_MAX;
      end
    endcase
    sat_s = {3'd0, pre_info.step};
    if (item_i.encoder_up) begin
      sat_n = (sat_v >= sat_hi - sat_s) ? sat_hi : sat_v + sat_s;
    end else begin
      sat_n = (sat_v <= sat_lo + sat_s) ? sat_lo : sat_v - sat_s;
    end
    changed   = (sat_n != sat_v);
    ampl_back = sat_n[12:0] - 13'(AMPL_OFFSET);
  end

  always_comb begin
    freq_d    = freq_q;
    ampl_d    = ampl_q;
    fm_d      = fm_q;
    pm_d      = pm_q;
    am_d      = am_q;
    sel_d     = sel_q;
    enc_d     = enc_q;
    mode_d    = mode_q;
    src_d     = src_q;
    rf_off_d  = rf_off_q;
    inhibit_d = inhibit_q;
    idx_d     = idx_q;
    act_d     = act_q;
    blank_d   = blank_q;
    left_d    = left_q;
    last_d    = last_q;
    status    = EVT_NONE;
    idx_cur   = idx_q[enc_q];
    elapsed   = item_i.now_ms - last_q;
    left_dec  = (left_q != 4'd0) ? left_q - 4'd1 : 4'd0;

    case (req_e'(item_i.req_type))
      REQ_KEY: begin
        case (key_e'(item_i.key_code))
          KEY_RF, KEY_AMPL, KEY_FM, KEY_PM, KEY_AM: begin
            sel_d = tgt_e'(item_i.key_code[2:0]);
            case (tgt_e'(item_i.key_code[2:0]))
              TGT_FM:  mode_d = MOD_FM;
              TGT_PM:  mode_d = MOD_PM;
              TGT_AM:  mode_d = MOD_AM;
              default: mode_d = mode_q;
            endcase
            act_d = 1'b0;
          end
          KEY_X10, KEY_DIV10: begin
            if (item_i.key_code == KEY_X10) begin
              if (idx_cur < max_index(enc_q)) idx_d[enc_q] = idx_cur + 3'd1;
            end else begin
              if (idx_cur > 3'd0) idx_d[enc_q] = idx_cur - 3'd1;
            end
            act_d   = 1'b1;
            blank_d = 1'b1;
            left_d  = phase_tot_q;
            last_d  = item_i.now_ms;
          end
          KEY_VALID: begin
            enc_d     = sel_q;
            inhibit_d = 1'b0;
          end
          KEY_RFOFF: rf_off_d = ~rf_off_q;
          KEY_CW, KEY_400HZ, KEY_1KHZ, KEY_EXT: begin
            src_d = 2'(item_i.key_code - KEY_CW);
          end
          default: ;
        endcase
      end
      REQ_ENC: begin
        if (inhibit_q) begin
          status = EVT_LOCKED;
        end else begin
          case (enc_q)
            TGT_AMPL: ampl_d = ampl_back[11:0];
            TGT_FM:   fm_d   = sat_n[17:0];
            TGT_PM:   pm_d   = sat_n[10:0];
            TGT_AM:   am_d   = sat_n[9:0];
            default:  freq_d = sat_n;
          endcase
          status = changed ? EVT_APPLIED : EVT_LIMIT;
        end
      end
      REQ_TICK: begin
        if (act_q && elapsed >= {16'd0, phase_ms_q}) begin
          last_d  = item_i.now_ms;
          blank_d = ~blank_q;
          left_d  = left_dec;
          if (left_dec == 4'd0) begin
            act_d   = 1'b0;
            blank_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  ipvs_step u_post (
    .target_i  (enc_d),
    .idx_i     (idx_d),
    .fm_dev_i  (fm_d),
    .blank_on_i(act_d & blank_d),
    .info_o    (post_info)
  );

  always_comb begin
    case (mode_d)
      MOD_FM:  modv = fm_d;
      MOD_PM:  modv = {7'd0, pm_d};
      default: modv = {8'd0, am_d};
    endcase
    res_o.event_status = status;
    res_o.carrier_hz   = freq_d;
    res_o.level_ddbm   = ampl_d;
    res_o.mod_value    = modv;
    res_o.target       = sel_d;
    res_o.enc_target   = enc_d;
    res_o.mod_mode     = mode_d;
    res_o.mod_source   = src_d;
    res_o.flags        = {inhibit_d, rf_off_d};
    res_o.current_step = post_info.step;
    res_o.blank_field  = post_info.field;
    res_o.blank_mask   = post_info.mask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q      <= FREQ_MIN;
      ampl_q      <= AMPL_RST;
      fm_q        <= '0;
      pm_q        <= '0;
      am_q        <= '0;
      sel_q       <= TGT_FREQ;
      enc_q       <= TGT_FREQ;
      mode_q      <= MOD_AM;
      src_q       <= '0;
      rf_off_q    <= 1'b1;
      inhibit_q   <= 1'b1;
      idx_q       <= '0;
      act_q       <= 1'b0;
      blank_q     <= 1'b0;
      left_q      <= '0;
      last_q      <= '0;
      phase_ms_q  <= BLINK_MS_RST;
      phase_tot_q <= BLINK_TOT_RST;
    end else begin
      if (advance_i) begin
        freq_q    <= freq_d;
        ampl_q    <= ampl_d;
        fm_q      <= fm_d;
        pm_q      <= pm_d;
        am_q      <= am_d;
        sel_q     <= sel_d;
        enc_q     <= enc_d;
        mode_q    <= mode_d;
        src_q     <= src_d;
        rf_off_q  <= rf_off_d;
        inhibit_q <= inhibit_d;
        idx_q     <= idx_d;
        act_q     <= act_d;
        blank_q   <= blank_d;
        left_q    <= left_d;
        last_q    <= last_d;
      end
      if (cfg_we_i) begin
        case (cfg_e'(cfg_addr_i))
          CFG_BLINK_MS:    phase_ms_q  <= cfg_wdata_i;
          CFG_BLINK_TOTAL: phase_tot_q <= cfg_wdata_i[3:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== rtl/instrument_panel_value_stepper.sv =====
// ----------------------------------------------------------------------------
// instrument_panel_value_stepper
// Front-panel controller of a signal generator: keys, encoder and ticks in,
// panel state, wheel step and digit blank mask out.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                   Payload
//   -------   -------------------------   ----------------------------------
//   input     in_valid_i / in_stall_o     req_type, key_code, encoder_up,
//                                         now_ms
//   result    out_valid_o / out_stall_i   event_status ... blank_mask
//   config    cfg_we_i                    cfg_addr_i, cfg_wdata_i
//
// Each word passes through the input register and then the result register,
// and one word is accepted every cycle while the result is not stalled.
// The state update for a word is finished in the cycle it leaves the input
// register, which is what holds throughput at one word per cycle.
// Reset sets the power-on panel state and the blink registers to 150 ms and
// six phases. A stalled result holds; one further word waits in the input
// register before in_stall_o is raised.
//
module instrument_panel_value_stepper import ipvs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Input channel.
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        req_type_i,
  input  logic [3:0]        key_code_i,
  input  logic              encoder_up_i,
  input  logic [31:0]       now_ms_i,
  // Result channel.
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        event_status_o,
  output logic [29:0]       carrier_hz_o,
  output logic signed [11:0] level_ddbm_o,
  output logic [17:0]       mod_value_o,
  output logic [2:0]        target_o,
  output logic [2:0]        enc_target_o,
  output logic [1:0]        mod_mode_o,
  output logic [1:0]        mod_source_o,
  output logic [1:0]        flags_o,
  output logic [26:0]       current_step_o,
  output logic [1:0]        blank_field_o,
  output logic [8:0]        blank_mask_o,
  // Configuration write port.
  input  logic              cfg_we_i,
  input  logic              cfg_addr_i,
  input  logic [15:0]       cfg_wdata_i
);

  logic    in_full_q, in_full_d;
  item_t   in_q;
  logic    out_full_q, out_full_d;
  result_t res_q;
  result_t res_d;
  logic    advance;
  logic    in_take;

  // A word moves on from the input register when the result register is
  // empty or its current word is taken in this same cycle.
  assign advance    = in_full_q & (~out_full_q | ~out_stall_i);
  assign in_stall_o = in_full_q & ~advance;
  assign in_take    = in_valid_i & ~in_stall_o;

  always_comb begin
    in_full_d = in_full_q;
    if (in_take) begin
      in_full_d = 1'b1;
    end else if (advance) begin
      in_full_d = 1'b0;
    end
    out_full_d = out_full_q;
    if (advance) begin
      out_full_d = 1'b1;
    end else if (!out_stall_i) begin
      out_full_d = 1'b0;
    end
  end

  ipvs_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .item_i     (in_q),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .res_o      (res_d)
  );

  // Handshake flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q  <= 1'b0;
      out_full_q <= 1'b0;
    end else begin
      in_full_q  <= in_full_d;
      out_full_q <= out_full_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.req_type   <= req_type_i;
      in_q.key_code   <= key_code_i;
      in_q.encoder_up <= encoder_up_i;
      in_q.now_ms     <= now_ms_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_full_q;
  assign event_status_o = res_q.event_status;
  assign carrier_hz_o   = res_q.carrier_hz;
  assign level_ddbm_o   = res_q.level_ddbm;
  assign mod_value_o    = res_q.mod_value;
  assign target_o       = res_q.target;
  assign enc_target_o   = res_q.enc_target;
  assign mod_mode_o     = res_q.mod_mode;
  assign mod_source_o   = res_q.mod_source;
  assign flags_o        = res_q.flags;
  assign current_step_o = res_q.current_step;
  assign blank_field_o  = res_q.blank_field;
  assign blank_mask_o   = res_q.blank_mask;

endmodule

// ===== tb/instrument_panel_value_stepper_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// instrument_panel_value_stepper_tb
// Self-checking bench for the front-panel value stepper. A short scripted
// sequence walks every key, the encoder in both directions, blink ticks
// across the millisecond wrap and the ignored codes. Random panel traffic
// then follows under five blink settings. Every result word is compared
// field by field with a behavioural model of the panel kept in this bench.
// ----------------------------------------------------------------------------
module instrument_panel_value_stepper_tb;
  import ipvs_pkg::*;

  // Codes that the block must ignore; the package has no names for them.
  localparam logic [1:0]  REQ_SPARE    = 2'd3;
  localparam logic [3:0]  KEY_SPARE_LO = 4'd13;
  localparam logic [3:0]  KEY_SPARE_HI = 4'd15;
  // Bit positions within the flags output.
  localparam int          FLAG_RF_OFF  = 0;
  localparam int          FLAG_LOCKED  = 1;
  localparam int          AMPL_TOP     = 130;
  localparam int          WORDS_EACH   = 205;
  localparam int          HOLD_CYCLES  = 80;
  localparam int          CYCLE_LIMIT  = 500000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [1:0]        req_type_i = REQ_KEY;
  logic [3:0]        key_code_i = KEY_RF;
  logic              encoder_up_i = 1'b0;
  logic [31:0]       now_ms_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [1:0]        event_status_o;
  logic [29:0]       carrier_hz_o;
  logic signed [11:0] level_ddbm_o;
  logic [17:0]       mod_value_o;
  logic [2:0]        target_o;
  logic [2:0]        enc_target_o;
  logic [1:0]        mod_mode_o;
  logic [1:0]        mod_source_o;
  logic [1:0]        flags_o;
  logic [26:0]       current_step_o;
  logic [1:0]        blank_field_o;
  logic [8:0]        blank_mask_o;
  logic              cfg_we_i = 1'b0;
  logic              cfg_addr_i = CFG_BLINK_MS;
  logic [15:0]       cfg_wdata_i = '0;

  instrument_panel_value_stepper dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .req_type_i, .key_code_i, .encoder_up_i, .now_ms_i,
    .out_valid_o, .out_stall_i, .event_status_o, .carrier_hz_o,
    .level_ddbm_o, .mod_value_o, .target_o, .enc_target_o,
    .mod_mode_o, .mod_source_o, .flags_o, .current_step_o,
    .blank_field_o, .blank_mask_o,
    .cfg_we_i, .cfg_addr_i, .cfg_wdata_i
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Panel model. Each adjustable parameter lives in val[] at the index of its
  // target, so the encoder path is one saturating add for all five of them.
  // The declarations carry the power-on state of the block.
  // --------------------------------------------------------------------------
  int          val [5]    = '{int'(FREQ_MIN), int'(AMPL_RST), 0, 0, 0};
  int          val_lo [5] = '{int'(FREQ_MIN), int'(AMPL_RST), 0, 0, 0};
  int          val_hi [5] = '{int'(FREQ_MAX), AMPL_TOP, int'(FM_MAX), int'(PM_MAX),
                              int'(AM_MAX)};
  int          step_idx [5] = '{0, 0, 0, 0, 0};
  tgt_e        sel_tgt     = TGT_FREQ;
  tgt_e        wheel_tgt   = TGT_FREQ;
  mod_e        mode        = MOD_AM;
  logic [1:0]  source      = 2'd0;
  logic [1:0]  panel_flags = 2'b11;
  logic        blinking    = 1'b0;
  logic        blanked     = 1'b0;
  logic [3:0]  phases_left = '0;
  logic [31:0] last_flip   = '0;
  logic [15:0] phase_ms    = BLINK_MS_RST;
  logic [3:0]  phase_total = BLINK_TOT_RST;

  // Results the block still owes, oldest first.
  result_t     expected_panels [$];

  int          mismatches = 0;
  int          results_seen = 0;
  int          steps_applied = 0;
  int          steps_at_limit = 0;
  int          blanked_results = 0;
  int          words_sent = 0;
  int          held_cycles = 0;
  int          holds_done = 0;
  int          cycle_count = 0;

  function automatic int index_top(input tgt_e t);
    case (t)
      TGT_AMPL, TGT_AM: return 2;
      TGT_FM:           return 4;
      TGT_PM:           return 3;
      default:          return 7;
    endcase
  endfunction

  function automatic int wheel_idx();
    return (step_idx[wheel_tgt] > index_top(wheel_tgt)) ? index_top(wheel_tgt)
                                                        : step_idx[wheel_tgt];
  endfunction

  // Frequency and FM tables start at ten, the others at one. Coarse FM
  // deviations cannot be stepped finer than the minimum FM step.
  function automatic int wheel_step();
    int s;
    s = 10 ** wheel_idx();
    if (wheel_tgt == TGT_FREQ || wheel_tgt == TGT_FM) s = s * 10;
    if (wheel_tgt == TGT_FM && val[TGT_FM] >= int'(FM_COARSE) && s < int'(FM_MIN_STEP))
      s = int'(FM_MIN_STEP);
    return s;
  endfunction

  function automatic fld_e wheel_field();
    case (wheel_tgt)
      TGT_FREQ: return FLD_FREQ;
      TGT_AMPL: return FLD_AMPL;
      default:  return FLD_MOD;
    endcase
  endfunction

  // The frequency step table starts at ten, so its step digit sits one place
  // above its index. FM counts digits in units of its display resolution. A
  // wide step in the modulation field blanks all three digits.
  function automatic logic [8:0] blank_digits();
    int pos;
    int sc;
    if (!(blinking && blanked)) return '0;
    case (wheel_tgt)
      TGT_FREQ: pos = wheel_idx() + 1;
      TGT_FM: begin
        sc = wheel_step() / ((val[TGT_FM] < int'(FM_COARSE)) ? 10 : 100);
        pos = 0;
        while (sc > 1) begin
          sc = sc / 10;
          pos++;
        end
      end
      default: pos = wheel_idx();
    endcase
    if (pos >= 3 && wheel_field() == FLD_MOD) return MOD_WIDE_MASK;
    if (pos > 8) return '0;
    return 9'(1 << pos);
  endfunction

  // Applies one panel word to the model and returns the panel state after it.
  task automatic panel_after_event(input logic [1:0] req, input logic [3:0] key,
                                   input logic up, input logic [31:0] now,
                                   output result_t panel);
    evt_e        status;
    int          s;
    int          n;
    int          modv;
    logic [31:0] since;
    status = EVT_NONE;
    case (req)
      REQ_KEY: begin
        case (key)
          KEY_RF, KEY_AMPL, KEY_FM, KEY_PM, KEY_AM: begin
            sel_tgt = tgt_e'(key[2:0]);
            if (key == KEY_FM) mode = MOD_FM;
            else if (key == KEY_PM) mode = MOD_PM;
            else if (key == KEY_AM) mode = MOD_AM;
            blinking = 1'b0;
          end
          KEY_X10, KEY_DIV10: begin
            // The index sticks at its ends, but the blink restarts anyway.
            if (key == KEY_X10 && step_idx[wheel_tgt] < index_top(wheel_tgt))
              step_idx[wheel_tgt]++;
            else if (key == KEY_DIV10 && step_idx[wheel_tgt] > 0)
              step_idx[wheel_tgt]--;
            blinking = 1'b1;
            blanked = 1'b1;
            phases_left = phase_total;
            last_flip = now;
          end
          KEY_VALID: begin
            wheel_tgt = sel_tgt;
            panel_flags[FLAG_LOCKED] = 1'b0;
          end
          KEY_RFOFF: panel_flags[FLAG_RF_OFF] = ~panel_flags[FLAG_RF_OFF];
          KEY_CW, KEY_400HZ, KEY_1KHZ, KEY_EXT: source = 2'(key - KEY_CW);
          default: ;
        endcase
      end
      REQ_ENC: begin
        if (panel_flags[FLAG_LOCKED]) begin
          status = EVT_LOCKED;
        end else begin
          s = wheel_step();
          n = up ? val[wheel_tgt] + s : val[wheel_tgt] - s;
          if (n > val_hi[wheel_tgt]) n = val_hi[wheel_tgt];
          if (n < val_lo[wheel_tgt]) n = val_lo[wheel_tgt];
          status = (n != val[wheel_tgt]) ? EVT_APPLIED : EVT_LIMIT;
          val[wheel_tgt] = n;
        end
      end
      REQ_TICK: begin
        // Elapsed time is taken modulo 2^32 so the millisecond wrap is seamless.
        since = now - last_flip;
        if (blinking && since >= {16'd0, phase_ms}) begin
          last_flip = now;
          blanked = ~blanked;
          if (phases_left != 0) phases_left--;
          if (phases_left == 0) begin
            blinking = 1'b0;
            blanked = 1'b0;
          end
        end
      end
      default: ;
    endcase

    case (mode)
      MOD_FM:  modv = val[TGT_FM];
      MOD_PM:  modv = val[TGT_PM];
      default: modv = val[TGT_AM];
    endcase

    panel.event_status = status;
    panel.carrier_hz   = 30'(val[TGT_FREQ]);
    panel.level_ddbm   = 12'(val[TGT_AMPL]);
    panel.mod_value    = 18'(modv);
    panel.target       = sel_tgt;
    panel.enc_target   = wheel_tgt;
    panel.mod_mode     = mode;
    panel.mod_source   = source;
    panel.flags        = panel_flags;
    panel.current_step = 27'(wheel_step());
    panel.blank_field  = wheel_field();
    panel.blank_mask   = blank_digits();
  endtask

  // --------------------------------------------------------------------------
  // Scripted opening. Only rows whose outcome is obvious carry a pinned status,
  // frequency and step; the rest are checked against the model alone.
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic [1:0]  req;
    logic [3:0]  key;
    logic        up;
    logic [31:0] now;
    logic        pinned;
    evt_e        status;
    logic [29:0] freq;
    logic [26:0] step;
  } script_row_t;

  script_row_t script [25] = '{
    // Wheel still inhibited straight out of reset.
    '{REQ_ENC,   KEY_EXT,      1'b1, 32'd0,         1'b1, EVT_LOCKED,  30'd100000, 27'd10},
    '{REQ_KEY,   KEY_VALID,    1'b0, 32'd1,         1'b0, EVT_NONE,    30'd0,      27'd0},
    // Already at the bottom of the frequency range.
    '{REQ_ENC,   KEY_RF,       1'b0, 32'd2,         1'b1, EVT_LIMIT,   30'd100000, 27'd10},
    '{REQ_ENC,   KEY_RF,       1'b1, 32'd3,         1'b1, EVT_APPLIED, 30'd100010, 27'd10},
    // Finer step at index zero: index stays, blink starts just before the wrap.
    '{REQ_KEY,   KEY_DIV10,    1'b0, 32'hFFFF_FF00, 1'b0, EVT_NONE,    30'd0,      27'd0},
    '{REQ_TICK,  KEY_RF,       1'b0, 32'h0000_0010, 1'b0, EVT_NONE,    30'd0,      27'd0},
    '{REQ_TICK,  KEY_RF,       1'b1, 32'hFFFF_FFFF, 1'b0, EVT_NONE,    30'd0,      27'd0},
    '{REQ_KEY,   KEY_X10,      1'b0, 32'd20,        1'b0, EVT_NONE,    30'd0,      27'd0},
    // Selecting a target stops the blink.
    '{REQ_KEY,   KEY_AMPL,     1'b0, 32'd21,        1'b0, EVT_NONE,    30'd0,      27'd0},
    '{REQ_KEY,   KEY_VALID,    1'b0, 32'd22,        1'b0, EVT_NONE,    30'd0,      27'd0},
    '{REQ_ENC,   KEY_RF,       1'b0, 32'd23,        1'b1, EVT_LIMIT,   30'd100010, 27'd1},
    '{REQ_KEY,   KEY_FM,       1'b1, 32'd24,        1'b0, EVT_NONE,    30'd0,      27'd0},
    '{REQ_KEY,   KEY_VALID,    1'b0, 32'd25,        1'b0, EVT_NONE,    30'd0,      27'd0},
    '{REQ_KEY,   KEY_PM,       1'b0, 32'd26,        1'b0, EVT_NONE,    30'd0,      27'd0},
    '{REQ_KEY,   KEY_AM,       1'b0, 32'd27,        1'b0, EVT_NONE,    30'd0,      27'd0},
    '{REQ_KEY,   KEY_RFOFF,    1'b0, 32'd28,        1'b0, EVT_NONE,    30'd0,      27'd0},
    '{REQ_KEY,   KEY_CW,       1'b0, 32'd29,        1'b0, EVT_NONE,    30'd0,      27'd0},
    '{REQ_KEY,   KEY_400HZ,    1'b0, 32'd30,        1'b0, EVT_NONE,    30'd0,      27'd0},
    '{REQ_KEY,   KEY_1KHZ,     1'b0, 32'd31,        1'b0, EVT_NONE,    30'd0,      27'd0},
    '{REQ_KEY,   KEY_EXT,      1'b0, 32'd32,        1'b0, EVT_NONE,    30'd0,      27'd0},
    // Unused key codes and the unused request type change nothing.
    '{REQ_KEY,   KEY_SPARE_LO, 1'b0, 32'd33,        1'b0, EVT_NONE,    30'd0,      27'd0},
    '{REQ_KEY,   KEY_SPARE_HI, 1'b1, 32'd34,        1'b0, EVT_NONE,    30'd0,      27'd0},
    '{REQ_SPARE, KEY_X10,      1'b1, 32'hFFFF_FFFF, 1'b0, EVT_NONE,    30'd0,      27'd0},
    '{REQ_KEY,   KEY_RF,       1'b0, 32'd36,        1'b0, EVT_NONE,    30'd0,      27'd0},
    // The wheel is still on FM although the selection has moved on.
    '{REQ_ENC,   KEY_RF,       1'b1, 32'd37,        1'b0, EVT_NONE,    30'd0,      27'd0}
  };

  // --------------------------------------------------------------------------
  // Input side. The expected panel is queued before the word is offered, so
  // it is always waiting by the time the block can answer.
  // --------------------------------------------------------------------------
  logic tx_calm = 1'b0;

  task automatic send_word(input logic [1:0] req, input logic [3:0] key, input logic up,
                           input logic [31:0] now, input result_t panel);
    int gap;
    int pick;
    expected_panels.push_back(panel);
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    key_code_i   <= key;
    encoder_up_i <= up;
    now_ms_i     <= now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
    // Runs of back-to-back words alternate with runs of mostly short gaps.
    if ($urandom_range(0, 49) == 0) tx_calm = ~tx_calm;
    gap = 0;
    if (!tx_calm) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) gap = $urandom_range(10, 40);
      else if (pick < 40) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stops offering words, waits until the block has answered every one, which
  // leaves its two-stage pipeline empty, and then idles before going on.
  task automatic wait_until_settled();
    in_valid_i <= 1'b0;
    while (expected_panels.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Both blink registers are written back to back with the block idle.
  task automatic set_blink(input logic [15:0] ms, input logic [3:0] total);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CFG_BLINK_MS;
    cfg_wdata_i <= ms;
    @(posedge clk_i);
    cfg_addr_i  <= CFG_BLINK_TOTAL;
    cfg_wdata_i <= {12'd0, total};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    phase_ms    = ms;
    phase_total = total;
  endtask

  // --------------------------------------------------------------------------
  // Result side. Random short stalls come in runs, and twice the receiver
  // holds off for a long stretch while words keep coming, which backs the
  // block up until it stalls its input.
  // --------------------------------------------------------------------------
  int   hold_left = 0;
  int   stall_left = 0;
  int   next_hold_at = 300;
  logic rx_calm = 1'b0;

  always @(posedge clk_i) begin
    if (hold_left == 0 && words_sent >= next_hold_at) begin
      hold_left = HOLD_CYCLES;
      next_hold_at += 400;
      holds_done++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      if ($urandom_range(0, 99) < 2) rx_calm = ~rx_calm;
      if (!rx_calm && $urandom_range(0, 99) < 30) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20)
                                                 : $urandom_range(0, 1);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 50)
        $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Result words are sampled at the edge that accepts them.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_panels.size() == 0) begin
        mismatches++;
        if (mismatches <= 50)
          $display("%0t ns: result word with none expected, got status %0d", $time,
                   event_status_o);
      end else begin
        want = expected_panels.pop_front();
        if (want.event_status == EVT_APPLIED) steps_applied++;
        if (want.event_status == EVT_LIMIT) steps_at_limit++;
        if (want.blank_mask != '0) blanked_results++;
        check_field("event_status", want.event_status, event_status_o);
        check_field("carrier_hz", want.carrier_hz, carrier_hz_o);
        check_field("level_ddbm", $signed(want.level_ddbm), $signed(level_ddbm_o));
        check_field("mod_value", want.mod_value, mod_value_o);
        check_field("target", want.target, target_o);
        check_field("enc_target", want.enc_target, enc_target_o);
        check_field("mod_mode", want.mod_mode, mod_mode_o);
        check_field("mod_source", want.mod_source, mod_source_o);
        check_field("flags", want.flags, flags_o);
        check_field("current_step", want.current_step, current_step_o);
        check_field("blank_field", want.blank_field, blank_field_o);
        check_field("blank_mask", want.blank_mask, blank_mask_o);
      end
    end
  end

  // Watchdog, and a tally of cycles in which the block refused input.
  always @(posedge clk_i) begin
    cycle_count++;
    if (rst_ni && in_valid_i && in_stall_o) held_cycles++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timed out after %0d cycles with %0d results outstanding", cycle_count,
               expected_panels.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence: reset, the scripted opening under the reset blink timing,
  // then random traffic under five blink settings. The third setting uses zero for
  // both registers, where every tick is due and the first one ends the blink.
  // --------------------------------------------------------------------------
  initial begin
    logic [15:0] ms_set [5];
    logic [3:0]  total_set [5];
    result_t     panel;
    logic [1:0]  req;
    logic [3:0]  key;
    logic        up;
    logic        dir_up;
    logic        want_valid;
    logic [31:0] clock_ms;
    logic [31:0] raw_ms;
    int          pick;
    int          n;

    ms_set    = '{BLINK_MS_RST, 16'd1, 16'd0, 16'hFFFF, 16'($urandom_range(1, 400))};
    total_set = '{BLINK_TOT_RST, 4'd1, 4'd0, 4'hF, 4'($urandom_range(1, 15))};
    dir_up = 1'b1;
    want_valid = 1'b0;
    clock_ms = 32'd1000;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < 5; ph++) begin
      // The first setting is the one the block comes out of reset with.
      if (ph != 0) set_blink(ms_set[ph], total_set[ph]);

      if (ph == 0) begin
        foreach (script[i]) begin
          panel_after_event(script[i].req, script[i].key, script[i].up, script[i].now, panel);
          if (script[i].pinned) begin
            panel.event_status = script[i].status;
            panel.carrier_hz   = script[i].freq;
            panel.current_step = script[i].step;
          end
          send_word(script[i].req, script[i].key, script[i].up, script[i].now, panel);
        end
      end

      // Mostly sensible panel use: select then validate, step changes, runs of
      // detents in one direction, ticks with time moving on. A few words are
      // raw noise over the whole field ranges.
      for (n = 0; n < WORDS_EACH; n++) begin
        req = REQ_KEY;
        key = KEY_RF;
        up = 1'($urandom_range(0, 1));
        clock_ms += $urandom_range(0, 3);
        pick = $urandom_range(0, 99);
        if (want_valid && pick < 85) begin
          key = KEY_VALID;
        end else if (pick < 42) begin
          req = REQ_ENC;
          if ($urandom_range(0, 99) < 8) dir_up = ~dir_up;
          up = dir_up;
        end else if (pick < 60) begin
          req = REQ_TICK;
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: clock_ms += $urandom_range(0, 200);
            6, 7, 8:          clock_ms += $urandom_range(0, 2 * int'(phase_ms) + 1);
            default:          clock_ms += $urandom();
          endcase
        end else if (pick < 70) begin
          key = $urandom_range(0, 1) ? KEY_X10 : KEY_DIV10;
        end else if (pick < 80) begin
          key = 4'($urandom_range(KEY_RF, KEY_AM));
        end else if (pick < 84) begin
          key = KEY_VALID;
        end else if (pick < 88) begin
          key = KEY_RFOFF;
        end else if (pick < 94) begin
          key = 4'($urandom_range(KEY_CW, KEY_EXT));
        end else begin
          req = 2'($urandom_range(0, 3));
          key = 4'($urandom_range(0, 15));
        end
        want_valid = (req == REQ_KEY && key <= KEY_AM);
        if (pick >= 94) begin
          raw_ms = $urandom();
          panel_after_event(req, key, up, raw_ms, panel);
          send_word(req, key, up, raw_ms, panel);
        end else begin
          panel_after_event(req, key, up, clock_ms, panel);
          send_word(req, key, up, clock_ms, panel);
        end
      end

      wait_until_settled();
    end

    $display("%0d panel words under 5 blink settings: %0d steps applied, %0d at a limit",
             words_sent, steps_applied, steps_at_limit);
    $display("%0d results with digits blanked; input refused for %0d cycles over %0d hold-offs",
             blanked_results, held_cycles, holds_done);
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ipvs_pkg.sv
rtl/ipvs_step.sv
rtl/ipvs_core.sv
rtl/instrument_panel_value_stepper.sv
tb/instrument_panel_value_stepper_tb.sv
